// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define QRS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked assertion, also checked during reset
`define QRS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- rtl/qrs_pkg.sv -----
// Package for the quadratic root solver: field widths, fixed-point
// constants and result status codes. No dependencies.
package qrs_pkg;

  localparam int IN_FIELD_W = 16;
  localparam int OUT_W      = 34;
  localparam int SQRT_FRAC  = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    ST_TWO     = 2'd0,
    ST_DOUBLE  = 2'd1,
    ST_COMPLEX = 2'd2,
    ST_AZERO   = 2'd3
  } status_t;

endpackage

// ----- rtl/qrs_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Carries a sideband vector alongside. Uses qrs_pkg.
module qrs_sqrt #(
  parameter int RW = 50,
  parameter int SW = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  logic [RW-1:0]       in_rad,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [RW/2-1:0]     out_root,
  output logic [SW-1:0]       out_side
);
  import qrs_pkg::*;

  localparam int RB = RW / 2;

  logic          vld  [1:RB];
  logic [RW-1:0] rad  [1:RB];
  logic [RB:0]   rem  [1:RB];
  logic [RB-1:0] root [1:RB];
  logic [SW-1:0] side [1:RB];

  for (genvar k = 1; k <= RB; k++) begin : g_stage
    logic          p_vld;
    logic [RW-1:0] p_rad;
    logic [RB:0]   p_rem;
    logic [RB-1:0] p_root;
    logic [SW-1:0] p_side;
    logic [RB+2:0] cur;
    logic [RB+2:0] trial;
    logic [RB+2:0] diff;
    logic          ge;

    if (k == 1) begin : g_first
      assign p_vld  = in_valid;
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_rad  = rad[k-1];
      assign p_rem  = rem[k-1];
      assign p_root = root[k-1];
      assign p_side = side[k-1];
    end

    assign cur   = {p_rem, p_rad[RW-1:RW-2]};
    assign trial = (RB+3)'({p_root, 2'b01});
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rad[k]  <= p_rad << 2;
        rem[k]  <= ge ? diff[RB:0] : cur[RB:0];
        root[k] <= {p_root[RB-2:0], ge};
        side[k] <= p_side;
      end
    end
  end

  assign out_valid = vld[RB];
  assign out_root  = root[RB];
  assign out_side  = side[RB];

endmodule

// ----- rtl/qrs_div.sv -----
// Pipelined restoring divider, two numerator lanes over one shared
// denominator, one quotient bit per stage. Uses qrs_pkg.
module qrs_div #(
  parameter int NW = 35,
  parameter int DW = 17,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num_lo,
  input  logic [NW-1:0] in_num_hi,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo_lo,
  output logic [NW-1:0] out_quo_hi,
  output logic [SW-1:0] out_side
);
  import qrs_pkg::*;

  logic          vld  [1:NW];
  logic [NW-1:0] nq_lo [1:NW];
  logic [NW-1:0] nq_hi [1:NW];
  logic [DW-1:0] rm_lo [1:NW];
  logic [DW-1:0] rm_hi [1:NW];
  logic [DW-1:0] den  [1:NW];
  logic [SW-1:0] side [1:NW];

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic          p_vld;
    logic [NW-1:0] p_nq_lo, p_nq_hi;
    logic [DW-1:0] p_rm_lo, p_rm_hi, p_den;
    logic [SW-1:0] p_side;
    logic [DW:0]   cur_lo, cur_hi, dif_lo, dif_hi;
    logic          ge_lo, ge_hi;

    if (k == 1) begin : g_first
      assign p_vld   = in_valid;
      assign p_nq_lo = in_num_lo;
      assign p_nq_hi = in_num_hi;
      assign p_rm_lo = '0;
      assign p_rm_hi = '0;
      assign p_den   = in_den;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_vld   = vld[k-1];
      assign p_nq_lo = nq_lo[k-1];
      assign p_nq_hi = nq_hi[k-1];
      assign p_rm_lo = rm_lo[k-1];
      assign p_rm_hi = rm_hi[k-1];
      assign p_den   = den[k-1];
      assign p_side  = side[k-1];
    end

    assign cur_lo = {p_rm_lo, p_nq_lo[NW-1]};
    assign cur_hi = {p_rm_hi, p_nq_hi[NW-1]};
    assign ge_lo  = cur_lo >= {1'b0, p_den};
    assign ge_hi  = cur_hi >= {1'b0, p_den};
    assign dif_lo = cur_lo - {1'b0, p_den};
    assign dif_hi = cur_hi - {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        nq_lo[k] <= {p_nq_lo[NW-2:0], ge_lo};
        nq_hi[k] <= {p_nq_hi[NW-2:0], ge_hi};
        rm_lo[k] <= ge_lo ? dif_lo[DW-1:0] : cur_lo[DW-1:0];
        rm_hi[k] <= ge_hi ? dif_hi[DW-1:0] : cur_hi[DW-1:0];
        den[k]   <= p_den;
        side[k]  <= p_side;
      end
    end
  end

  assign out_valid  = vld[NW];
  assign out_quo_lo = nq_lo[NW];
  assign out_quo_hi = nq_hi[NW];
  assign out_side   = side[NW];

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// Quadratic root solver top level: discriminant, square root and divider
// pipelines with an output skid stage. Uses qrs_pkg, qrs_sqrt, qrs_div.
//
// Takes one coefficient set (a, b, c) per cycle and returns one result per
// request, in order: the real roots (-b -/+ sqrt(b*b-4ac))/(2a) in signed
// fixed point with FRAC_BITS fraction bits, truncated toward zero, the root
// of the discriminant itself truncated to 8 fraction bits. Status tells two
// roots, a double root, complex roots or a zero a; roots read zero for the
// last two. RB = (2*COEF_WIDTH+18)/2 is the square root depth and NW =
// max(COEF_WIDTH+FRAC_BITS, RB+FRAC_BITS-8)+2 the divider depth, one bit
// per stage each. Throughput is one request per cycle while s_tready is
// high; the skid stage at the output holds one more result while a result
// waits, and s_tready drops while the skid stage is full.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  input  logic [qrs_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // root_low [33:0], root_high [67:34], zero [71:68]
  output logic [qrs_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status [1:0]
  output logic [1:0]                      m_tuser
);
  import qrs_pkg::*;

  localparam int CW  = COEF_WIDTH;
  localparam int DSW = 2 * CW + 1;
  localparam int RW  = 2 * ((DSW + 2 * SQRT_FRAC + 1) / 2);
  localparam int RB  = RW / 2;
  localparam int NA  = CW + FRAC_BITS;
  localparam int NB  = RB + FRAC_BITS - SQRT_FRAC;
  localparam int NW  = ((NA > NB) ? NA : NB) + 2;
  localparam int QW  = (NW > OUT_W + 1) ? NW : OUT_W + 1;
  localparam int SSW = 2 + 2 * CW;
  localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (OUT_W - 1));

  logic ce;
  logic skid_valid;

  // stage 1: input capture
  logic                 v1;
  logic signed [CW-1:0] a1, b1, c1;
  // stage 2: products
  logic                   v2;
  logic signed [2*CW-1:0] bb2, ac2;
  logic signed [CW-1:0]   a2, b2;
  // stage 3: discriminant and status
  logic                   v3;
  logic [RW-1:0]          rad3;
  logic [SSW-1:0]         side3;
  logic signed [2*CW+2:0] disc;
  status_t                stat_c;
  // square root output
  logic                   v4;
  logic [RB-1:0]          root4;
  logic [SSW-1:0]         side4;
  // stage 5: numerators
  logic                   v5;
  logic [NW-1:0]          mlo5, mhi5;
  logic [CW:0]            den5;
  logic [3:0]             side5;
  logic signed [CW-1:0]   a4, b4;
  logic signed [NW-1:0]   nb, sr, nlo, nhi;
  logic [CW-1:0]          absa;
  // divider output
  logic                   v6;
  logic [NW-1:0]          qlo6, qhi6;
  logic [3:0]             side6;
  // stage 7: sign, saturation
  logic                   v7;
  logic [OUT_W-1:0]       lo7, hi7;
  status_t                stat7;
  logic [OUT_W-1:0]       lo_c, hi_c;
  status_t                stat6;
  logic [QW-1:0]          qel, qeh;
  // output and skid
  logic [OUT_W-1:0]       out_lo, out_hi, sk_lo, sk_hi;
  status_t                out_stat, sk_stat;
  logic                   take;

  assign ce       = !skid_valid;
  assign s_tready = ce;
  assign take     = v7 && ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v5 <= 1'b0;
      v7 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v5 <= v4;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1 <= $signed(CW'(s_tdata[IN_FIELD_W-1:0]));
      b1 <= $signed(CW'(s_tdata[2*IN_FIELD_W-1:IN_FIELD_W]));
      c1 <= $signed(CW'(s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]));
      bb2 <= b1 * b1;
      ac2 <= a1 * c1;
      a2  <= a1;
      b2  <= b1;
    end
  end

  assign disc = (2*CW+3)'(bb2) - ((2*CW+3)'(ac2) <<< 2);

  always_comb begin
    if (a2 == '0) begin
      stat_c = ST_AZERO;
    end else if (disc < 0) begin
      stat_c = ST_COMPLEX;
    end else if (disc == '0) begin
      stat_c = ST_DOUBLE;
    end else begin
      stat_c = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rad3  <= disc[2*CW+2] ? '0 : (RW'(disc[DSW-1:0]) << (2 * SQRT_FRAC));
      side3 <= {stat_c, a2, b2};
    end
  end

  qrs_sqrt #(.RW(RW), .SW(SSW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v3),
    .in_rad    (rad3),
    .in_side   (side3),
    .out_valid (v4),
    .out_root  (root4),
    .out_side  (side4)
  );

  assign a4   = $signed(side4[2*CW-1:CW]);
  assign b4   = $signed(side4[CW-1:0]);
  assign nb   = -(NW'(b4) <<< FRAC_BITS);
  assign sr   = $signed(NW'(root4) << (FRAC_BITS - SQRT_FRAC));
  assign nlo  = nb - sr;
  assign nhi  = nb + sr;
  assign absa = a4[CW-1] ? CW'(-a4) : CW'(a4);

  always_ff @(posedge clk) begin
    if (ce) begin
      mlo5  <= nlo[NW-1] ? NW'(-nlo) : NW'(nlo);
      mhi5  <= nhi[NW-1] ? NW'(-nhi) : NW'(nhi);
      den5  <= {absa, 1'b0};
      side5 <= {side4[SSW-1:SSW-2], nlo[NW-1] ^ a4[CW-1], nhi[NW-1] ^ a4[CW-1]};
    end
  end

  qrs_div #(.NW(NW), .DW(CW + 1), .SW(4)) u_div (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (v5),
    .in_num_lo  (mlo5),
    .in_num_hi  (mhi5),
    .in_den     (den5),
    .in_side    (side5),
    .out_valid  (v6),
    .out_quo_lo (qlo6),
    .out_quo_hi (qhi6),
    .out_side   (side6)
  );

  assign stat6 = status_t'(side6[3:2]);
  assign qel   = QW'(qlo6);
  assign qeh   = QW'(qhi6);

  always_comb begin
    if (side6[1]) begin
      lo_c = (qel > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(-qel);
    end else begin
      lo_c = (qel > POS_LIM) ? OUT_W'(POS_LIM) : OUT_W'(qel);
    end
    if (side6[0]) begin
      hi_c = (qeh > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(-qeh);
    end else begin
      hi_c = (qeh > POS_LIM) ? OUT_W'(POS_LIM) : OUT_W'(qeh);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      stat7 <= stat6;
      if (stat6 == ST_COMPLEX || stat6 == ST_AZERO) begin
        lo7 <= '0;
        hi7 <= '0;
      end else begin
        lo7 <= lo_c;
        hi7 <= hi_c;
      end
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_lo   <= sk_lo;
        out_hi   <= sk_hi;
        out_stat <= sk_stat;
      end else begin
        out_lo   <= lo7;
        out_hi   <= hi7;
        out_stat <= stat7;
      end
    end else if (take) begin
      sk_lo   <= lo7;
      sk_hi   <= hi7;
      sk_stat <= stat7;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 2 * OUT_W){1'b0}}, out_hi, out_lo};
  assign m_tuser = out_stat;

endmodule

// ----- rtl/qrs_checker.sv -----
// Port-level checks for quadratic_root_solver, bound to the top level.
// Uses qrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [qrs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [1:0]                      m_tuser
);
  import qrs_pkg::*;

  `QRS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `QRS_ASSERT(a_no_root_zero, clk, rst, m_tvalid && (m_tuser == ST_COMPLEX || m_tuser == ST_AZERO) |-> m_tdata == '0, "roots not zero for complex or zero a")
  `QRS_ASSERT(a_double_eq, clk, rst, m_tvalid && m_tuser == ST_DOUBLE |-> m_tdata[OUT_W-1:0] == m_tdata[2*OUT_W-1:OUT_W], "double root with unequal roots")
  `QRS_ASSERT_ALWAYS(a_rst_idle, clk, $past(rst) |-> !m_tvalid, "result valid right after reset")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Testbench for quadratic_root_solver: streams coefficient sets through the
// block and checks roots and status against a local integer root predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
module tb_top;
  import qrs_pkg::*;

  localparam int FRAC_W = 16;
  localparam int LATENCY = 66;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [OUT_W-1:0] root_low;
    logic signed [OUT_W-1:0] root_high;
    status_t                 status;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  roots_t expected_roots[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int hold_len = 0;
  bit burst_gaps = 1'b1;

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned disc_sqrt_q8(longint unsigned d);
    longint unsigned rem, root, pair, trial;
    rem = 0;
    root = 0;
    for (int i = 31 + SQRT_FRAC; i >= 0; i--) begin
      pair = (i >= SQRT_FRAC) ? ((d >> (2 * (i - SQRT_FRAC))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_root(longint v);
    longint hi_lim, lo_lim;
    hi_lim = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo_lim = -(longint'(1) <<< (OUT_W - 1));
    if (v > hi_lim) v = hi_lim;
    if (v < lo_lim) v = lo_lim;
    return v[OUT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                         logic signed [15:0] c);
    roots_t r;
    longint la, lb, lc, disc, nb, sr, den;
    la = a;
    lb = b;
    lc = c;
    r = '0;
    if (la == 0) begin
      r.status = ST_AZERO;
      return r;
    end
    disc = lb * lb - 4 * la * lc;
    if (disc < 0) begin
      r.status = ST_COMPLEX;
      return r;
    end
    sr = longint'(disc_sqrt_q8(disc)) * (longint'(1) <<< (FRAC_W - SQRT_FRAC));
    nb = -lb * (longint'(1) <<< FRAC_W);
    den = 2 * la;
    r.root_low = clamp_root((nb - sr) / den);
    r.root_high = clamp_root((nb + sr) / den);
    r.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
    return r;
  endfunction

  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    if (burst_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tdata <= {c, b, a};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_roots.push_back(solve_roots(a, b, c));
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk);
  endtask

  task automatic test_special_cases();
    send_coefs(16'sd0, 16'sd5, 16'sd3);
    send_coefs(16'sd0, 16'h8000, 16'h7fff);
    send_coefs(16'sd1, 16'sd0, 16'sd1);
    send_coefs(16'sd1, 16'sd2, 16'sd1);
    send_coefs(-16'sd3, 16'sd6, -16'sd3);
    send_coefs(16'sd1, -16'sd3, 16'sd2);
    send_coefs(16'sd2, 16'sd0, -16'sd1);
    send_coefs(16'sd1, 16'sd0, 16'sd0);
  endtask

  task automatic test_extremes();
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'sd1, 16'h8000, 16'h8000);
    send_coefs(16'sd1, 16'h7fff, 16'h7fff);
    send_coefs(-16'sd1, 16'h8000, 16'h7fff);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'sd1, 16'sd1, 16'sd0);
    send_coefs(16'h4000, 16'h8000, 16'h4000);
  endtask

  task automatic test_random(int count);
    logic [15:0] a, b, c;
    int hb, ai;
    for (int i = 0; i < count; i++) begin
      a = 16'($urandom());
      b = 16'($urandom());
      c = 16'($urandom());
      case ($urandom_range(0, 5))
        0: a = 16'(int'($urandom_range(0, 7)) - 3);
        1: c = 16'(int'($urandom_range(0, 15)) - 8);
        2: begin
          a = 16'($urandom_range(1, 200));
          c = -$signed(16'($urandom_range(0, 500)));
        end
        3: begin
          hb = int'($urandom_range(0, 200)) - 100;
          ai = int'($urandom_range(1, 50));
          a = 16'(ai);
          if (hb % ai == 0) begin
            b = 16'(2 * hb);
            c = 16'(hb * hb / ai);
          end else begin
            b = '0;
            c = '0;
          end
        end
        default: ;
      endcase
      send_coefs(a, b, c);
    end
  endtask

  task automatic test_back_pressure();
    burst_gaps = 1'b0;
    hold_len = 150;
    hold_off = 1'b1;
    test_random(120);
    burst_gaps = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_extremes();
    drain_results();
    test_random(250);
    test_back_pressure();
    test_random(150);
    drain_results();
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_off = 1'b0;
      end
      phase++;
      if ((phase / 200) % 2 == 1)
        m_tready <= 1'b1;
      else
        m_tready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    roots_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.root_low = m_tdata[OUT_W-1:0];
      got.root_high = m_tdata[2*OUT_W-1:OUT_W];
      got.status = status_t'(m_tuser);
      if (expected_roots.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = expected_roots.pop_front();
        if (got.root_low !== want.root_low) begin
          $error("root_low expected %0d got %0d", want.root_low, got.root_low);
          errors++;
        end
        if (got.root_high !== want.root_high) begin
          $error("root_high expected %0d got %0d", want.root_high, got.root_high);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end
endmodule
